### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk; the first is off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define SPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sorted priority queue check failed");
// Checked on every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes and the cell control type.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH     = 8;
	localparam int PRIO_BITS = 16;
	localparam int TAG_BITS  = 32;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int FILL_BITS = 4;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic enq;         // insert the new entry this cycle
		logic deq;         // remove the head this cycle
		logic valid;       // this cell holds an entry
		logic left_valid;  // left neighbor holds an entry
		logic left_gt;     // left neighbor's priority is above the new one
	} spq_cell_ctrl_t;

endpackage

### design/spq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic signed [PRIO_BITS-1:0] prio_in;
	logic        [TAG_BITS-1:0]  tag_in;

	modport source (output valid, mode, prio_in, tag_in, input ready);
	modport sink   (input valid, mode, prio_in, tag_in, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic        [1:0]           status;
	logic signed [PRIO_BITS-1:0] prio_out;
	logic        [TAG_BITS-1:0]  tag_out;
	logic        [FILL_BITS-1:0] fill;

	modport source (output valid, status, prio_out, tag_out, fill, input ready);
	modport sink   (input valid, status, prio_out, tag_out, fill, output ready);
endinterface

### design/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic                        clk,
	input  spq_cell_ctrl_t              ctrl,
	input  logic signed [PRIO_BITS-1:0] new_prio,
	input  logic        [TAG_BITS-1:0]  new_tag,
	input  logic signed [PRIO_BITS-1:0] left_prio,
	input  logic        [TAG_BITS-1:0]  left_tag,
	input  logic signed [PRIO_BITS-1:0] right_prio,
	input  logic        [TAG_BITS-1:0]  right_tag,
	output logic signed [PRIO_BITS-1:0] prio,
	output logic        [TAG_BITS-1:0]  tag,
	output logic                        gt
);

	logic signed [PRIO_BITS-1:0] prio_q;
	logic        [TAG_BITS-1:0]  tag_q;
	logic                        take_new;

	// Equal priorities do not count as greater, so a new entry lands behind them.
	assign gt = ctrl.valid && (prio_q > new_prio);

	assign take_new = (!ctrl.valid || gt) && ctrl.left_valid && !ctrl.left_gt;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (ctrl.left_gt) begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end else if (take_new) begin
				prio_q <= new_prio;
				tag_q  <= new_tag;
			end
		end else if (ctrl.deq) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

### design/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue kept sorted by ascending signed priority in a row of cells.
// ----------------------------------------------------------------------------
// Usage: each request on req is an enqueue (mode 0, with prio_in and tag_in)
// or a dequeue (mode 1). Every request yields exactly one response on rsp
// with a status, the removed entry for a successful dequeue (zero otherwise)
// and the number of entries held afterwards.
// Smaller priority numbers leave first; equal priorities leave in arrival
// order. An enqueue into a full queue reports full and changes nothing; a
// dequeue from an empty queue reports empty.
// The response is registered at the edge that takes the request. Throughput
// is one request per cycle while the receiver takes each response, since every
// cell compares its priority with the new one in parallel and shifts in the same edge.
// The response register is the only buffer: while a response waits, a new
// request is taken only in the cycle the receiver takes the old one.
// Reset clears the entry count and the response valid; the slots hold no
// reset value and are only read below the count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue_unit
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic                        req_fire;
	logic                        enq_fire;
	logic                        deq_fire;
	logic [CNT_BITS-1:0]         count_q;
	logic [CNT_BITS-1:0]         count_d;
	logic                        full;
	logic                        empty;

	logic                        rsp_valid_q;
	logic [1:0]                  status_q;
	logic signed [PRIO_BITS-1:0] prio_out_q;
	logic [TAG_BITS-1:0]         tag_out_q;
	logic [FILL_BITS-1:0]        fill_q;

	spq_cell_ctrl_t              cell_ctrl [DEPTH];
	logic signed [PRIO_BITS-1:0] cell_prio [DEPTH];
	logic [TAG_BITS-1:0]         cell_tag  [DEPTH];
	logic                        cell_gt   [DEPTH];

	assign full  = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign enq_fire  = req_fire && (req.mode == MODE_ENQ) && !full;
	assign deq_fire  = req_fire && (req.mode == MODE_DEQ) && !empty;

	always_comb begin
		count_d = count_q;
		if (enq_fire) begin
			count_d = count_q + CNT_BITS'(1);
		end else if (deq_fire) begin
			count_d = count_q - CNT_BITS'(1);
		end
	end

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic signed [PRIO_BITS-1:0] left_prio;
			logic [TAG_BITS-1:0]         left_tag;
			logic signed [PRIO_BITS-1:0] right_prio;
			logic [TAG_BITS-1:0]         right_tag;

			// The head cell sees a virtual left neighbor that is valid and not greater.
			if (i == 0) begin : g_head
				assign left_prio                = cell_prio[i];
				assign left_tag                 = cell_tag[i];
				assign cell_ctrl[i].left_valid  = 1'b1;
				assign cell_ctrl[i].left_gt     = 1'b0;
			end else begin : g_body
				assign left_prio                = cell_prio[i-1];
				assign left_tag                 = cell_tag[i-1];
				assign cell_ctrl[i].left_valid  = cell_ctrl[i-1].valid;
				assign cell_ctrl[i].left_gt     = cell_gt[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign right_prio = cell_prio[i];
				assign right_tag  = cell_tag[i];
			end else begin : g_mid
				assign right_prio = cell_prio[i+1];
				assign right_tag  = cell_tag[i+1];
			end

			assign cell_ctrl[i].enq   = enq_fire;
			assign cell_ctrl[i].deq   = deq_fire;
			assign cell_ctrl[i].valid = (count_q > CNT_BITS'(i));

			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.new_prio   (req.prio_in),
				.new_tag    (req.tag_in),
				.left_prio  (left_prio),
				.left_tag   (left_tag),
				.right_prio (right_prio),
				.right_tag  (right_tag),
				.prio       (cell_prio[i]),
				.tag        (cell_tag[i]),
				.gt         (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			fill_q <= FILL_BITS'(count_d);
			if (req.mode == MODE_ENQ) begin
				status_q   <= full ? ST_FULL : ST_DONE;
				prio_out_q <= '0;
				tag_out_q  <= '0;
			end else if (empty) begin
				status_q   <= ST_EMPTY;
				prio_out_q <= '0;
				tag_out_q  <= '0;
			end else begin
				status_q   <= ST_DONE;
				prio_out_q <= cell_prio[0];
				tag_out_q  <= cell_tag[0];
			end
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.prio_out = prio_out_q;
	assign rsp.tag_out  = tag_out_q;
	assign rsp.fill     = fill_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_BITS'(DEPTH))
	`SPQ_ASSERT(a_full_rejects, (req_fire && req.mode == MODE_ENQ && full) |=> (rsp.status == ST_FULL && $stable(count_q)))
	`SPQ_ASSERT(a_deq_counts_down, deq_fire |=> (count_q == $past(count_q) - CNT_BITS'(1) && rsp.status == ST_DONE))
	`SPQ_ASSERT(a_head_sorted, (count_q >= CNT_BITS'(2)) |-> (cell_prio[0] <= cell_prio[1]))

endmodule

### dv/spq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue order checker
// Watches the request and response channels and keeps its own sorted copy of
// the queue. Each accepted request yields one expected response, and each
// accepted response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module spq_order_checker
	import spq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   full_rejects,
	output int   empty_reports
);

	typedef struct {
		logic        [1:0]           status;
		logic signed [PRIO_BITS-1:0] prio;
		logic        [TAG_BITS-1:0]  tag;
		logic        [FILL_BITS-1:0] fill;
	} spq_result_t;

	logic signed [PRIO_BITS-1:0] model_prio [DEPTH];
	logic        [TAG_BITS-1:0]  model_tag  [DEPTH];
	int                          model_held;

	spq_result_t expected_rsp [$];
	spq_result_t want;

	// Applies one request to the model queue and returns the response it owes.
	function automatic spq_result_t apply_request(logic op,
			logic signed [PRIO_BITS-1:0] p, logic [TAG_BITS-1:0] t);
		spq_result_t r;
		int          pos;
		r.status = ST_DONE;
		r.prio   = '0;
		r.tag    = '0;
		if (op == MODE_ENQ) begin
			if (model_held >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// The new entry lands behind every entry of equal or lower priority.
				pos = model_held;
				while (pos > 0 && model_prio[pos-1] > p)
					pos--;
				for (int k = model_held; k > pos; k--) begin
					model_prio[k] = model_prio[k-1];
					model_tag[k]  = model_tag[k-1];
				end
				model_prio[pos] = p;
				model_tag[pos]  = t;
				model_held++;
			end
		end else if (model_held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.prio = model_prio[0];
			r.tag  = model_tag[0];
			for (int k = 0; k + 1 < model_held; k++) begin
				model_prio[k] = model_prio[k+1];
				model_tag[k]  = model_tag[k+1];
			end
			model_held--;
		end
		r.fill = FILL_BITS'(model_held);
		return r;
	endfunction

	task automatic compare_field(string name, longint exp_val, longint got_val);
		if (exp_val != got_val) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$realtime, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_held = 0;
			expected_rsp.delete();
			mismatches    = 0;
			full_rejects  = 0;
			empty_reports = 0;
		end else begin
			// A response taken at this edge always belongs to an earlier request.
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					$display("%0t ns: response with none expected, status %0d prio %0d tag %0d fill %0d",
						$realtime, rsp.status, rsp.prio_out, rsp.tag_out, rsp.fill);
				end else begin
					want = expected_rsp.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("prio_out", want.prio, rsp.prio_out);
					compare_field("tag_out", want.tag, rsp.tag_out);
					compare_field("fill", want.fill, rsp.fill);
					if (want.status == ST_FULL)
						full_rejects++;
					if (want.status == ST_EMPTY)
						empty_reports++;
				end
			end
			if (req.valid && req.ready)
				expected_rsp.push_back(apply_request(req.mode, req.prio_in, req.tag_in));
		end
		outstanding = expected_rsp.size();
	end

endmodule

### dv/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives directed and random enqueue and dequeue requests in bursts against a
// stalling receiver; the order checker predicts and compares every response.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 1450;
	localparam int CYCLE_LIMIT     = 200000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   full_rejects;
	int   empty_reports;
	int   cycle_count;
	int   stall_tick;
	int   enq_sent;
	int   deq_sent;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	spq_order_checker order_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.full_rejects  (full_rejects),
		.empty_reports (empty_reports)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, outstanding);
			$display("sorted_priority_queue_unit verification failed");
			$finish;
		end
	end

	// The receiver cycles through always ready, coin flip, mostly stalled and a
	// fixed short stall, so backpressure lands on every phase of the sender.
	always @(negedge clk) begin
		stall_tick++;
		case ((stall_tick / 97) % 4)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready <= (stall_tick % 7) > 2;
		endcase
	end

	task automatic send_request(logic op, logic signed [PRIO_BITS-1:0] p,
			logic [TAG_BITS-1:0] t);
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= op;
		req_ch.prio_in <= p;
		req_ch.tag_in  <= t;
		do @(posedge clk); while (!req_ch.ready);
		if (op == MODE_ENQ)
			enq_sent++;
		else
			deq_sent++;
	endtask

	task automatic idle_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	task automatic drain_queue();
		idle_sender(1);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int                          sent;
		int                          burst;
		int                          enq_pct;
		logic                        op;
		logic signed [PRIO_BITS-1:0] p;

		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.mode    = MODE_ENQ;
		req_ch.prio_in = '0;
		req_ch.tag_in  = '0;
		rsp_ch.ready   = 1'b0;
		cycle_count    = 0;
		stall_tick     = 0;
		enq_sent       = 0;
		deq_sent       = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty dequeue, extremes, equal priorities, full rejection.
		send_request(MODE_DEQ, 16'sd0, 32'h0);
		send_request(MODE_ENQ, 16'sh7fff, 32'hffff_ffff);
		send_request(MODE_ENQ, -16'sd32768, 32'h0);
		send_request(MODE_ENQ, 16'sd5, 32'haaaa_0001);
		send_request(MODE_ENQ, 16'sd5, 32'haaaa_0002);
		send_request(MODE_ENQ, 16'sd5, 32'haaaa_0003);
		send_request(MODE_ENQ, -16'sd1, 32'h5555_5555);
		send_request(MODE_ENQ, 16'sd0, 32'h1234_5678);
		send_request(MODE_ENQ, 16'sh7fff, 32'h0000_0001);
		send_request(MODE_ENQ, -16'sd32768, 32'hdead_beef);
		repeat (8)
			send_request(MODE_DEQ, 16'sh7fff, 32'hffff_ffff);
		send_request(MODE_DEQ, -16'sd1, 32'hffff_ffff);
		drain_queue();

		sent    = 0;
		enq_pct = 50;
		while (sent < RANDOM_REQUESTS) begin
			// Shift the enqueue share now and then so the queue swings between
			// full and empty instead of hovering in the middle.
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: enq_pct = 85;
					1: enq_pct = 15;
					2: enq_pct = 55;
					default: enq_pct = 40;
				endcase
			end
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				op = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
				case ($urandom_range(0, 3))
					0: begin
						p = PRIO_BITS'($urandom_range(0, 6));
						p = p - 16'sd3;
					end
					1: begin
						case ($urandom_range(0, 3))
							0: p = -16'sd32768;
							1: p = 16'sh7fff;
							2: p = -16'sd1;
							default: p = 16'sd0;
						endcase
					end
					default: p = PRIO_BITS'($urandom);
				endcase
				send_request(op, p, $urandom);
				sent++;
			end
			if (sent % 300 < burst)
				drain_queue();
			else if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 6));
		end

		drain_queue();
		repeat (8) @(negedge clk);
		$display("Ran %0d enqueues and %0d dequeues with random gaps and receiver stalls;",
			enq_sent, deq_sent);
		$display("%0d inserts were rejected as full and %0d dequeues found the queue empty.",
			full_rejects, empty_reports);
		if (mismatches == 0)
			$display("sorted_priority_queue_unit verification clean");
		else
			$display("sorted_priority_queue_unit verification failed");
		$finish;
	end

endmodule
